// ===== rtl/csr_pkg.sv =====
// Types and constants shared by the CAN segment reassembler modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csr_pkg;

  localparam logic [2:0] TYPE_FIRST  = 3'h2;
  localparam logic [2:0] TYPE_CONSEC = 3'h3;
  localparam logic [3:0] MAX_FRAME_BYTES = 4'h8;

  localparam logic [7:0] MAX_MESSAGE_BYTES   = 8'd255;
  localparam logic [7:0] MIN_SEGMENTED_BYTES = 8'd9;

  localparam logic [1:0] STS_PROGRESS = 2'd0;
  localparam logic [1:0] STS_COMPLETE = 2'd1;
  localparam logic [1:0] STS_NOT_SEG  = 2'd2;
  localparam logic [1:0] STS_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic [10:0] std_id;
    logic [17:0] ext_id;
    logic [3:0]  byte_count;
    logic [63:0] payload_data;
  } frame_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        overflow;
    logic [4:0]  word_index;
    logic [63:0] data_word;
    logic        last;
    logic [7:0]  msg_id;
    logic [3:0]  source_node;
    logic [7:0]  total_length;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic write_byte;
    logic start_read;
    logic read_word;
    logic emit_single;
    logic emit_word;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic segment;
    logic cnt_zero;
    logic complete;
    logic last_word;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/can_segment_reassembler.sv =====
// Top level of the CAN segment reassembler: controller plus datapath.
// Depends on csr_pkg, csr_ctrl and csr_datapath.
//
//   channel  dir  payload            handshake
//   frame    in   csr_pkg::frame_t   frame_valid / frame_stall
//   result   out  csr_pkg::result_t  result_valid / result_stall
//
// One frame at a time: capture, then decode; a segment frame then stores its bytes
// one at a time (up to 8, one store write port) and passes a check state. A single
// result then loads into the result register. A completed message gives its words
// in turn (registered row read, then output load), up to 32.
// Reset (rst, synchronous) clears the message state; the store needs no clearing.
// A stalled result holds the sequencer until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
module can_segment_reassembler (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             frame_valid,
  output logic                  frame_stall,
  input  wire csr_pkg::frame_t  frame,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output csr_pkg::result_t      result
);

  csr_pkg::cmd_t cmd;
  csr_pkg::sts_t sts;

  csr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  csr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== rtl/csr_ctrl.sv =====
// Sequencing controller for the CAN segment reassembler.
// Depends on csr_pkg (cmd_t, sts_t).
`timescale 1ns / 1ps
`default_nettype none
module csr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          frame_valid,
  output logic               frame_stall,
  input  wire csr_pkg::sts_t sts,
  output csr_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_SINGLE = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state, state_next;

  assign frame_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.segment ? S_WRITE : S_SINGLE;
      end
      S_WRITE: begin
        if (sts.cnt_zero) begin
          state_next = S_CHECK;
        end else begin
          cmd.write_byte = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.complete) begin
          cmd.start_read = 1'b1;
          state_next     = S_READ;
        end else begin
          state_next = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_READ: begin
        cmd.read_word = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_word = 1'b1;
          state_next    = sts.last_word ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csr_datapath.sv =====
// Datapath of the CAN segment reassembler: frame register, message state,
// eight byte-lane stores and the result register. Depends on csr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csr_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csr_pkg::frame_t frame,
  input  wire csr_pkg::cmd_t   cmd,
  output csr_pkg::sts_t        sts,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output csr_pkg::result_t     result
);

  // captured frame; payload shifts down a byte per store write
  logic [10:0] f_std;
  logic [17:0] f_ext;
  logic [3:0]  f_count;
  logic [63:0] f_payload;

  // message state
  logic [7:0] expected_length;
  logic [7:0] received_count;
  logic [7:0] current_msg_id;
  logic [3:0] current_source;
  logic       done_flag;

  // per-request working registers
  logic [3:0] cnt;
  logic [4:0] word_k;
  logic [1:0] res_status;
  logic       res_ovf;

  // byte lane b holds message position 8*a + b at address a
  logic [7:0] lane_mem [8][32];
  logic [7:0] rdata [8];

  logic [2:0] ftype;
  logic [7:0] total;
  logic [3:0] n8;
  logic       is_first, is_consec, bad_total, no_msg;
  logic [7:0] room;
  logic [3:0] take;
  logic [4:0] last_k;
  logic [63:0] word_masked;
  logic       out_free;

  assign ftype     = f_std[2:0];
  assign total     = f_ext[7:0];
  assign n8        = (f_count > csr_pkg::MAX_FRAME_BYTES) ? csr_pkg::MAX_FRAME_BYTES : f_count;
  assign is_first  = (ftype == csr_pkg::TYPE_FIRST);
  assign is_consec = (ftype == csr_pkg::TYPE_CONSEC);
  assign bad_total = (total == 8'd0) || (total < csr_pkg::MIN_SEGMENTED_BYTES)
                     || (total > csr_pkg::MAX_MESSAGE_BYTES);
  assign no_msg    = (expected_length == 8'd0) || done_flag;

  always_comb begin
    if (is_first) begin
      room = total;
    end else if (expected_length > received_count) begin
      room = expected_length - received_count;
    end else begin
      room = 8'd0;
    end
    take = ({4'd0, n8} < room) ? n8 : room[3:0];
  end

  assign last_k   = 5'((expected_length - 8'd1) >> 3);
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if ({word_k, 3'(b)} < expected_length) begin
        word_masked[8*b +: 8] = rdata[b];
      end else begin
        word_masked[8*b +: 8] = 8'd0;
      end
    end
  end

  assign sts.segment   = (is_first && !bad_total) || (is_consec && !no_msg);
  assign sts.cnt_zero  = (cnt == 4'd0);
  assign sts.complete  = !(received_count < expected_length);
  assign sts.last_word = (word_k == last_k);
  assign sts.out_free  = out_free;

  // frame capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      f_std     <= frame.std_id;
      f_ext     <= frame.ext_id;
      f_count   <= frame.byte_count;
      f_payload <= frame.payload_data;
    end else if (cmd.write_byte) begin
      f_payload <= f_payload >> 8;
    end
    if (cmd.decide) begin
      if (is_first) begin
        res_status <= bad_total ? csr_pkg::STS_BAD_LEN : csr_pkg::STS_PROGRESS;
        res_ovf    <= bad_total ? 1'b0 : (take < n8);
      end else if (is_consec) begin
        res_status <= csr_pkg::STS_PROGRESS;
        res_ovf    <= no_msg ? (n8 != 4'd0) : (take < n8);
      end else begin
        res_status <= csr_pkg::STS_NOT_SEG;
        res_ovf    <= 1'b0;
      end
    end
  end

  // message state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 8'd0;
      received_count  <= 8'd0;
      current_msg_id  <= 8'd0;
      current_source  <= 4'd0;
      done_flag       <= 1'b0;
      cnt             <= 4'd0;
      word_k          <= 5'd0;
    end else begin
      if (cmd.decide) begin
        cnt <= sts.segment ? take : 4'd0;
        if (is_first && !bad_total) begin
          expected_length <= total;
          received_count  <= 8'd0;
          current_msg_id  <= f_ext[15:8];
          current_source  <= f_std[6:3];
          done_flag       <= 1'b0;
        end
      end
      if (cmd.write_byte) begin
        received_count <= received_count + 8'd1;
        cnt            <= cnt - 4'd1;
      end
      if (cmd.start_read) begin
        done_flag <= 1'b1;
        word_k    <= 5'd0;
      end
      if (cmd.emit_word) begin
        word_k <= word_k + 5'd1;
      end
    end
  end

  // byte-lane stores: one byte written, one full row read per cycle
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      lane_mem[received_count[2:0]][received_count[7:3]] <= f_payload[7:0];
    end
    if (cmd.read_word) begin
      for (int b = 0; b < 8; b++) begin
        rdata[b] <= lane_mem[b][word_k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_word) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single || cmd.emit_word) begin
      result.overflow     <= res_ovf;
      result.msg_id       <= current_msg_id;
      result.source_node  <= current_source;
      result.total_length <= expected_length;
      if (cmd.emit_word) begin
        result.status     <= csr_pkg::STS_COMPLETE;
        result.word_index <= word_k;
        result.data_word  <= word_masked;
        result.last       <= sts.last_word;
      end else begin
        result.status     <= res_status;
        result.word_index <= 5'd0;
        result.data_word  <= 64'd0;
        result.last       <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for can_segment_reassembler: CAN frames in, message words out.
// Depends on csr_pkg and the can_segment_reassembler RTL.
`timescale 1ns / 1ps
module tb;

  // Frame-by-frame predictor plus queue of results still owed by the block.
  class reassembly_tracker;
    logic [7:0]       msg_bytes [256];
    int               want_len;
    int               got_len;
    logic [7:0]       cur_id;
    logic [3:0]       cur_src;
    bit               msg_done;
    csr_pkg::result_t due_results [$];
    int               mismatches;

    function new();
      want_len   = 0;
      got_len    = 0;
      cur_id     = '0;
      cur_src    = '0;
      msg_done   = 1'b0;
      mismatches = 0;
    endfunction

    function void owe(logic [1:0] status, bit ovf, int idx, logic [63:0] word, bit last);
      csr_pkg::result_t r;
      r.status       = status;
      r.overflow     = ovf;
      r.word_index   = idx[4:0];
      r.data_word    = word;
      r.last         = last;
      r.msg_id       = cur_id;
      r.source_node  = cur_src;
      r.total_length = want_len[7:0];
      due_results.push_back(r);
    endfunction

    // Appends up to n bytes at the running count; returns 1 if any were clipped.
    function bit store_bytes(logic [63:0] data, int n);
      int room;
      int take;
      room = (want_len > got_len) ? want_len - got_len : 0;
      take = (n < room) ? n : room;
      for (int i = 0; i < take; i++) msg_bytes[(got_len + i) & 255] = data[8*i +: 8];
      got_len = (got_len + take) & 255;
      return take < n;
    endfunction

    function void take_frame(csr_pkg::frame_t f);
      logic [2:0]  kind;
      int          n;
      int          total;
      int          words;
      bit          ovf;
      logic [63:0] w;
      kind = f.std_id[2:0];
      n = (f.byte_count > csr_pkg::MAX_FRAME_BYTES) ? int'(csr_pkg::MAX_FRAME_BYTES)
                                                     : int'(f.byte_count);
      if (kind == csr_pkg::TYPE_FIRST) begin
        total = int'(f.ext_id[7:0]);
        if (total == 0 || total < csr_pkg::MIN_SEGMENTED_BYTES
            || total > csr_pkg::MAX_MESSAGE_BYTES) begin
          owe(csr_pkg::STS_BAD_LEN, 1'b0, 0, '0, 1'b1);
          return;
        end
        want_len = total;
        got_len  = 0;
        cur_id   = f.ext_id[15:8];
        cur_src  = f.std_id[6:3];
        msg_done = 1'b0;
        ovf = store_bytes(f.payload_data, n);
      end else if (kind == csr_pkg::TYPE_CONSEC) begin
        // nothing open, or already emitted: bytes are dropped as overflow
        if (want_len == 0 || msg_done) begin
          owe(csr_pkg::STS_PROGRESS, n > 0, 0, '0, 1'b1);
          return;
        end
        ovf = store_bytes(f.payload_data, n);
      end else begin
        owe(csr_pkg::STS_NOT_SEG, 1'b0, 0, '0, 1'b1);
        return;
      end
      if (got_len < want_len) begin
        owe(csr_pkg::STS_PROGRESS, ovf, 0, '0, 1'b1);
        return;
      end
      msg_done = 1'b1;
      words = (want_len + 7) / 8;
      for (int k = 0; k < words; k++) begin
        w = '0;
        for (int b = 0; b < 8; b++)
          if (k*8 + b < want_len) w[8*b +: 8] = msg_bytes[(k*8 + b) & 255];
        owe(csr_pkg::STS_COMPLETE, ovf, k, w, k + 1 == words);
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(csr_pkg::result_t got);
      csr_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: %0h", got);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("status", want.status, got.status);
      compare("overflow", want.overflow, got.overflow);
      compare("word_index", want.word_index, got.word_index);
      compare("data_word", want.data_word, got.data_word);
      compare("last", want.last, got.last);
      compare("msg_id", want.msg_id, got.msg_id);
      compare("source_node", want.source_node, got.source_node);
      compare("total_length", want.total_length, got.total_length);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             frame_valid;
  logic             frame_stall;
  csr_pkg::frame_t  frame;
  logic             result_valid;
  logic             result_stall;
  csr_pkg::result_t result;

  reassembly_tracker tracker = new();
  int items_sent = 0;
  bit idling     = 1'b0;
  bit quiet      = 1'b0;
  bit hold_off   = 1'b0;

  can_segment_reassembler dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [17:0] ext_field(logic [7:0] id, logic [7:0] low);
    logic [1:0] top;
    top = 2'($urandom_range(0, 3));
    return {top, id, low};
  endfunction

  function automatic csr_pkg::frame_t build_frame(logic [2:0] kind, logic [3:0] src,
                                                  logic [17:0] ext, logic [3:0] count,
                                                  logic [63:0] data);
    csr_pkg::frame_t f;
    logic [3:0] dest;
    dest           = 4'($urandom_range(0, 15));
    f.std_id       = {dest, src, kind};
    f.ext_id       = ext;
    f.byte_count   = count;
    f.payload_data = data;
    return f;
  endfunction

  function automatic logic [3:0] pick_count();
    if ($urandom_range(0, 5) == 0) return 4'($urandom_range(0, 15));
    return 4'd8;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid
  // still high, so back-to-back requests need no second assignment in one step.
  task automatic send_frame(csr_pkg::frame_t f);
    int gap;
    if (idling && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    tracker.take_frame(f);
    items_sent++;
    @(negedge clk);
  endtask

  // First frame then consecutive frames until the total is covered or max_frames is hit.
  task automatic send_message(int total, int max_frames);
    logic [3:0] src;
    logic [7:0] id;
    logic [3:0] cnt;
    int sent;
    int frames;
    src = 4'($urandom_range(0, 15));
    id  = 8'($urandom_range(0, 255));
    cnt = pick_count();
    send_frame(build_frame(csr_pkg::TYPE_FIRST, src, ext_field(id, total[7:0]), cnt,
                           rand64()));
    sent   = (cnt > 8) ? 8 : cnt;
    frames = 1;
    while (sent < total && frames < max_frames) begin
      cnt = pick_count();
      send_frame(build_frame(csr_pkg::TYPE_CONSEC, src, ext_field(id, frames[7:0]), cnt,
                             rand64()));
      sent += (cnt > 8) ? 8 : cnt;
      frames++;
    end
  endtask

  initial begin
    int total;
    int pick;
    frame_valid = 1'b0;
    frame       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idling = 1'b1;

    // consecutive frames with no message open
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'h3, ext_field(8'h00, 8'h01), 4'd5,
                           rand64()));
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'h3, ext_field(8'h00, 8'h02), 4'd0,
                           rand64()));
    // every type that is not a segment frame
    for (int k = 0; k < 8; k++)
      if (k != csr_pkg::TYPE_FIRST && k != csr_pkg::TYPE_CONSEC)
        send_frame(build_frame(3'(k), 4'($urandom_range(0, 15)),
                               18'($urandom_range(0, 262143)),
                               4'($urandom_range(0, 15)), rand64()));
    // totals out of bounds
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'h1, ext_field(8'h12, 8'h00), 4'd15,
                           rand64()));
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'h1,
                           ext_field(8'h12, csr_pkg::MIN_SEGMENTED_BYTES - 8'd1),
                           4'd8, rand64()));
    // shortest message, oversized count on the tail frame clips and flags overflow
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'hF,
                           ext_field(8'hFF, csr_pkg::MIN_SEGMENTED_BYTES), 4'd8,
                           64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'hF, ext_field(8'hFF, 8'h01), 4'd15,
                           rand64()));
    // late frame after completion
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'hF, ext_field(8'hFF, 8'h02), 4'd3,
                           rand64()));
    // exact fit, empty first frame
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'h0, ext_field(8'h00, 8'd16), 4'd0, 64'h0));
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'h0, ext_field(8'h00, 8'h01), 4'd8,
                           64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'h0, ext_field(8'h00, 8'h02), 4'd8,
                           rand64()));
    // a new first frame abandons the open message
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'h5, ext_field(8'h33, 8'd20), 4'd8,
                           rand64()));
    send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'h6, ext_field(8'h44, 8'd10), 4'd8,
                           rand64()));
    send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'h6, ext_field(8'h44, 8'h01), 4'd2,
                           rand64()));

    // longest message the block allows
    send_message(csr_pkg::MAX_MESSAGE_BYTES, 64);

    while (items_sent < 160) begin
      quiet  = items_sent >= 130;
      idling = $urandom_range(0, 3) != 0;
      pick   = $urandom_range(0, 9);
      if (pick == 0) begin
        send_frame(build_frame(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                               18'($urandom_range(0, 262143)),
                               4'($urandom_range(0, 15)), rand64()));
      end else if (pick == 1) begin
        total = $urandom_range(0, csr_pkg::MIN_SEGMENTED_BYTES - 1);
        send_frame(build_frame(csr_pkg::TYPE_FIRST, 4'($urandom_range(0, 15)),
                               ext_field(8'($urandom_range(0, 255)), total[7:0]),
                               pick_count(), rand64()));
      end else begin
        if ($urandom_range(0, 7) == 0) total = $urandom_range(41, csr_pkg::MAX_MESSAGE_BYTES);
        else total = $urandom_range(csr_pkg::MIN_SEGMENTED_BYTES, 40);
        // broken sequences may stop short and are then overtaken by the next first frame
        send_message(total, (pick == 2) ? $urandom_range(1, 3) : 64);
        if ($urandom_range(0, 3) == 0)
          send_frame(build_frame(csr_pkg::TYPE_CONSEC, 4'($urandom_range(0, 15)),
                                 ext_field(8'($urandom_range(0, 255)), 8'hEE),
                                 pick_count(), rand64()));
      end
    end
    frame_valid <= 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("can_segment_reassembler test passed");
    end else begin
      $display("can_segment_reassembler test failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus the long hold-off when requested.
  initial begin
    int burst;
    burst = 0;
    result_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        result_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        result_stall <= 1'b1;
      end else if (idling && !quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 3) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
      @(posedge clk);
      if (result_valid === 1'b1 && result_stall === 1'b0) tracker.check_result(result);
    end
  end

  // Hold results back long enough for the block to back up onto its input.
  initial begin
    wait (items_sent >= 60);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("can_segment_reassembler test failed");
    $finish;
  end

endmodule
